>>> src/sha512_stream_hasher_defines.svh
// Assertion macros for the stream hasher checker.
`ifndef SHA512_STREAM_HASHER_DEFINES_SVH
`define SHA512_STREAM_HASHER_DEFINES_SVH

// Clocked check, held off during reset.
`define SSH_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("stream hasher check failed");

// Clocked check that also holds during reset.
`define SSH_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("stream hasher check failed");

`endif

>>> src/ssh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssh_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         count_en;
      logic         load_v;
      logic         round_en;
      logic         chain_add;
      logic         out_adv;
      logic         msg_clear;
   } cmd_type;

   typedef struct packed {
      logic [6:0] fill;
      logic       round_last;
      logic       idx_last;
   } status_type;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [6:0] FILL_LAST  = 7'd127;
   localparam logic [6:0] FILL_LEN   = 7'd120;
   localparam logic [6:0] FILL_TWO   = 7'd112;
   localparam logic [6:0] ROUND_LAST = 7'd79;

   function automatic logic [63:0] iv_word(input logic [2:0] i);
      logic [63:0] r;
      unique case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         default: r = 64'h5be0cd19137e2179;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] round_k(input logic [6:0] t);
      logic [63:0] r;
      unique case (t)
         7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
         7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
         7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
         7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
         7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
         7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
         7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
         7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
         7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
         7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
         7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
         7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
         7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
         7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
         7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
         7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
         7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
         7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
         7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
         7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
         7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
         7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
         7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
         7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
         7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
         7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
         7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
         7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
         7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
         7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
         7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
         7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
         7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
         7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
         7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
         7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
         7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
         7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
         7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
         7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
         default: r = 64'h0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/ssh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ssh_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ssh_pkg::cmd_type cmd,
   input  wire logic [7:0]       data_byte,
   output ssh_pkg::status_type   status,
   output logic [63:0]           digest_word,
   output logic [2:0]            word_index
);

   logic [1023:0] block_ff, block_in;
   logic [6:0]    fill_ff, fill_in;
   logic [6:0]    round_ff, round_in;
   logic [63:0]   msg_ff, msg_in;
   logic [2:0]    idx_ff, idx_in;
   logic [63:0]   v_ff [8];
   logic [63:0]   v_in [8];
   logic [63:0]   chain_ff [8];
   logic [63:0]   chain_in [8];

   logic [7:0]  byte_val;
   logic [63:0] len_bits;
   logic [63:0] w0, w1, w9, w14, sg0, sg1, new_w;
   logic [63:0] e, a, bs1, bs0, ch, mj, t1, t2;

   assign len_bits = {msg_ff[60:0], 3'b000};
   assign w0  = block_ff[1023:960];
   assign w1  = block_ff[959:896];
   assign w9  = block_ff[447:384];
   assign w14 = block_ff[127:64];
   assign sg0 = {w1[0], w1[63:1]} ^ {w1[7:0], w1[63:8]} ^ (w1 >> 7);
   assign sg1 = {w14[18:0], w14[63:19]} ^ {w14[60:0], w14[63:61]} ^ (w14 >> 6);
   assign new_w = sg1 + w9 + sg0 + w0;

   assign e   = v_ff[4];
   assign a   = v_ff[0];
   assign bs1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
   assign bs0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
   assign ch  = (e & v_ff[5]) ^ (~e & v_ff[6]);
   assign mj  = (a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + bs1 + ch + ssh_pkg::round_k(round_ff) + w0;
   assign t2  = bs0 + mj;

   always_comb begin
      case (cmd.byte_sel)
         ssh_pkg::SEL_DATA: byte_val = data_byte;
         ssh_pkg::SEL_MARK: byte_val = ssh_pkg::PAD_MARK;
         ssh_pkg::SEL_LEN:  byte_val = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
         default:           byte_val = 8'h00;
      endcase
   end

   always_comb begin
      block_in = block_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      msg_in   = msg_ff;
      idx_in   = idx_ff;
      v_in     = v_ff;
      chain_in = chain_ff;
      if (cmd.shift_en) begin
         block_in = {block_ff[1015:0], byte_val};
         fill_in  = fill_ff + 7'd1;
      end
      if (cmd.count_en) begin
         msg_in = msg_ff + 64'd1;
      end
      if (cmd.load_v) begin
         v_in     = chain_ff;
         round_in = '0;
      end
      if (cmd.round_en) begin
         block_in = {block_ff[959:0], new_w};
         round_in = round_ff + 7'd1;
         v_in[7]  = v_ff[6];
         v_in[6]  = v_ff[5];
         v_in[5]  = v_ff[4];
         v_in[4]  = v_ff[3] + t1;
         v_in[3]  = v_ff[2];
         v_in[2]  = v_ff[1];
         v_in[1]  = v_ff[0];
         v_in[0]  = t1 + t2;
      end
      if (cmd.chain_add) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end
      if (cmd.out_adv) begin
         idx_in = idx_ff + 3'd1;
      end
      if (cmd.msg_clear) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = ssh_pkg::iv_word(3'(i));
         end
         fill_in = '0;
         msg_in  = '0;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      v_ff     <= v_in;
      if (reset) begin
         fill_ff  <= '0;
         round_ff <= '0;
         msg_ff   <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= ssh_pkg::iv_word(3'(i));
         end
      end else begin
         fill_ff  <= fill_in;
         round_ff <= round_in;
         msg_ff   <= msg_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == ssh_pkg::ROUND_LAST);
   assign status.idx_last   = (idx_ff == 3'd7);
   assign digest_word       = chain_ff[idx_ff];
   assign word_index        = idx_ff;

endmodule
`default_nettype wire

>>> src/ssh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ssh_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_kind,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire ssh_pkg::status_type status,
   output ssh_pkg::cmd_type         cmd
);

   ssh_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic               two_ff, two_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssh_pkg::ST_IDLE;
         ret_ff   <= ssh_pkg::ST_IDLE;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         two_ff   <= two_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      two_in       = two_ff;
      cmd          = '0;
      cmd.byte_sel = ssh_pkg::SEL_ZERO;
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ssh_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.shift_en = req_valid;
            cmd.count_en = req_valid & ~req_kind;
            cmd.byte_sel = req_kind ? ssh_pkg::SEL_MARK : ssh_pkg::SEL_DATA;
            if (req_valid) begin
               if (status.fill == ssh_pkg::FILL_LAST) begin
                  cmd.load_v = 1'b1;
                  state_in   = ssh_pkg::ST_COMP;
                  ret_in     = req_kind ? ssh_pkg::ST_PAD : ssh_pkg::ST_IDLE;
                  two_in     = 1'b0;
               end else if (req_kind) begin
                  two_in   = (status.fill >= ssh_pkg::FILL_TWO);
                  state_in = ssh_pkg::ST_PAD;
               end
            end
         end
         ssh_pkg::ST_PAD: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = (two_ff || status.fill < ssh_pkg::FILL_LEN) ?
                           ssh_pkg::SEL_ZERO : ssh_pkg::SEL_LEN;
            if (status.fill == ssh_pkg::FILL_LAST) begin
               cmd.load_v = 1'b1;
               state_in   = ssh_pkg::ST_COMP;
               ret_in     = two_ff ? ssh_pkg::ST_PAD : ssh_pkg::ST_OUT;
               two_in     = 1'b0;
            end
         end
         ssh_pkg::ST_COMP: begin
            cmd.round_en = 1'b1;
            if (status.round_last) begin
               state_in = ssh_pkg::ST_ADD;
            end
         end
         ssh_pkg::ST_ADD: begin
            cmd.chain_add = 1'b1;
            state_in      = ret_ff;
         end
         ssh_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.out_adv = 1'b1;
               if (status.idx_last) begin
                  cmd.msg_clear = 1'b1;
                  state_in      = ssh_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = ssh_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> src/sha512_stream_hasher.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// req       req_valid / req_stall    req_kind, req_data_byte
// rsp       rsp_valid / rsp_stall    rsp_digest_word, rsp_word_index, rsp_last_word
//
// Data bytes are taken while idle; every 128th byte starts a compression
// (80 rounds in one shared round unit, then the chaining add).
// A finish request pads one byte a cycle to the block end, compresses once or
// twice, then offers eight digest words, one per accepted response.
// Synchronous reset loads the initial hash and clears all counts.
// req_stall stays high through padding, compression and the digest words.
`default_nettype none
module sha512_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   ssh_pkg::cmd_type    cmd;
   ssh_pkg::status_type status;

   ssh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word),
      .word_index  (rsp_word_index)
   );

   assign rsp_last_word = status.idx_last;

endmodule
`default_nettype wire

>>> src/ssh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sha512_stream_hasher_defines.svh"
module ssh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   `SSH_ASSERT(a_no_req_during_rsp, rsp_valid |-> req_stall)
   `SSH_ASSERT(a_last_on_seven, rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
   `SSH_ASSERT(a_index_steps, (rsp_valid && !rsp_stall && !rsp_last_word) |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
   `SSH_ASSERT(a_stalled_holds, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word_index)))
   `SSH_ASSERT_ALWAYS(a_quiet_after_reset, reset |=> !rsp_valid)

endmodule

bind sha512_stream_hasher ssh_checker u_ssh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_word_index (rsp_word_index),
   .rsp_last_word  (rsp_last_word)
);
`default_nettype wire
